@@ hw/rtl/ohc_pkg.sv @@
// shared types and constants for the open handle cache
// no dependencies
package ohc_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 16;

    localparam int unsigned REQ_W   = 2;
    localparam int unsigned INDEX_W = 16;
    localparam int unsigned REV_W   = 16;
    localparam int unsigned TAG_W   = 16;
    localparam int unsigned FMT_W   = 3;
    localparam int unsigned AGE_W   = 32;
    localparam int unsigned LIMIT_W = 4;
    localparam int unsigned OPEN_W  = 5;

    localparam logic [LIMIT_W-1:0] MAX_OPEN_RESET = 4'd15;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_CLOSE  = 2'd2,
        REQ_NOP    = 2'd3
    } ohc_req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [TAG_W-1:0]   tag;
        logic [FMT_W-1:0]   fmt;
        logic [REV_W-1:0]   rev;
        logic [AGE_W-1:0]   age;
    } ohc_entry_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } ohc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } ohc_sts_t;

endpackage

@@ hw/rtl/ohc_ctrl.sv @@
// sequencing state machine for the open handle cache
// depends on ohc_pkg
module ohc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ohc_pkg::ohc_sts_t sts,
    output ohc_pkg::ohc_cmd_t cmd
);
    import ohc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                // no beat is taken while reset is held
                s_ready   = aresetn;
                cmd.start = s_valid && aresetn;
                if (s_valid && aresetn) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last entry read is compared here
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                cmd.commit = sts.out_free;
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/ohc_datapath.sv @@
// entry memory, valid bits, scan trackers and result register
// depends on ohc_pkg
module ohc_datapath #(
    parameter int unsigned TABLE_DEPTH = ohc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ohc_pkg::ohc_cmd_t             cmd,
    output ohc_pkg::ohc_sts_t             sts,
    input  logic                          cfg_valid,
    input  logic [ohc_pkg::LIMIT_W-1:0]   cfg_max_open,
    input  logic [ohc_pkg::REQ_W-1:0]     s_req_type,
    input  logic [ohc_pkg::INDEX_W-1:0]   s_file_index,
    input  logic [ohc_pkg::REV_W-1:0]     s_current_rev,
    input  logic [ohc_pkg::TAG_W-1:0]     s_new_tag,
    input  logic [ohc_pkg::FMT_W-1:0]     s_format_type,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic [ohc_pkg::TAG_W-1:0]     m_hit_tag,
    output logic                          m_sync_needed,
    output logic                          m_evicted,
    output logic [ohc_pkg::INDEX_W-1:0]   m_evicted_index,
    output logic [ohc_pkg::TAG_W-1:0]     m_evicted_tag,
    output logic [ohc_pkg::FMT_W-1:0]     m_evicted_format,
    output logic [ohc_pkg::OPEN_W-1:0]    m_open_count
);
    import ohc_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned LW = CW + LIMIT_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic [LW-1:0] LIMIT_CAP = LW'(TABLE_DEPTH - 1);

    // entry storage
    ohc_entry_t mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [CW-1:0]          count_reg, count_next, count_after;
    logic [AGE_W-1:0]       age_reg, age_next;
    logic [LIMIT_W-1:0]     max_open_reg;
    logic [LW-1:0]          limit;

    // latched request
    ohc_req_t           req_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [REV_W-1:0]   rev_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [FMT_W-1:0]   fmt_reg;

    // scan pipeline
    logic [AW-1:0] rd_addr_reg;
    ohc_entry_t    rd_data_reg;
    logic          cmp_en_reg;
    logic          cmp_valid_reg;
    logic [AW-1:0] cmp_slot_reg;
    logic          cmp_match, cmp_old, cmp_free;

    // trackers
    logic          match_found_reg, old_found_reg, free_found_reg;
    logic [AW-1:0] match_slot_reg, old_slot_reg, free_slot_reg;
    ohc_entry_t    match_ent_reg, old_ent_reg;

    // result register
    logic               m_valid_reg;
    logic               hit_reg, hit_next;
    logic [TAG_W-1:0]   hit_tag_reg, hit_tag_next;
    logic               sync_reg, sync_next;
    logic               ev_reg, ev_next;
    logic [INDEX_W-1:0] ev_index_reg, ev_index_next;
    logic [TAG_W-1:0]   ev_tag_reg, ev_tag_next;
    logic [FMT_W-1:0]   ev_fmt_reg, ev_fmt_next;
    logic [OPEN_W-1:0]  open_reg;
    logic               wr_en;

    assign sts.scan_last = (rd_addr_reg == LAST_ADDR);
    assign sts.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_open_reg <= MAX_OPEN_RESET;
        end else if (cfg_valid) begin
            max_open_reg <= cfg_max_open;
        end
    end

    // zero acts as one, and a free slot must always remain
    always_comb begin
        limit = {{CW{1'b0}}, max_open_reg};
        if (limit == '0) begin
            limit = LW'(1);
        end
        if (limit > LIMIT_CAP) begin
            limit = LIMIT_CAP;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            req_reg <= ohc_req_t'(s_req_type);
            idx_reg <= s_file_index;
            rev_reg <= s_current_rev;
            tag_reg <= s_new_tag;
            fmt_reg <= s_format_type;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_addr_reg <= '0;
            cmp_en_reg  <= 1'b0;
        end else begin
            cmp_en_reg <= cmd.scan;
            if (cmd.start) begin
                rd_addr_reg <= '0;
            end else if (cmd.scan) begin
                rd_addr_reg <= rd_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan) begin
            rd_data_reg   <= mem[rd_addr_reg];
            cmp_valid_reg <= valid_reg[rd_addr_reg];
            cmp_slot_reg  <= rd_addr_reg;
        end
        if (wr_en) begin
            mem[free_slot_reg] <= '{index: idx_reg, tag: tag_reg, fmt: fmt_reg,
                                    rev: rev_reg, age: age_reg};
        end
    end

    // strict compares keep the lowest slot on equal ages
    assign cmp_match = cmp_en_reg && cmp_valid_reg && (rd_data_reg.index == idx_reg)
                       && (!match_found_reg || (rd_data_reg.age > match_ent_reg.age));
    assign cmp_old   = cmp_en_reg && cmp_valid_reg
                       && (!old_found_reg || (rd_data_reg.age < old_ent_reg.age));
    assign cmp_free  = cmp_en_reg && !cmp_valid_reg && !free_found_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_found_reg <= 1'b0;
            old_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
        end else if (cmd.start) begin
            match_found_reg <= 1'b0;
            old_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
        end else begin
            if (cmp_match) begin
                match_found_reg <= 1'b1;
            end
            if (cmp_old) begin
                old_found_reg <= 1'b1;
            end
            if (cmp_free) begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmp_match) begin
            match_slot_reg <= cmp_slot_reg;
            match_ent_reg  <= rd_data_reg;
        end
        if (cmp_old) begin
            old_slot_reg <= cmp_slot_reg;
            old_ent_reg  <= rd_data_reg;
        end
        if (cmp_free) begin
            free_slot_reg <= cmp_slot_reg;
        end
    end

    always_comb begin
        valid_next    = valid_reg;
        count_next    = count_reg;
        count_after   = count_reg + CW'(1);
        age_next      = age_reg;
        wr_en         = 1'b0;
        hit_next      = 1'b0;
        hit_tag_next  = '0;
        sync_next     = 1'b0;
        ev_next       = 1'b0;
        ev_index_next = '0;
        ev_tag_next   = '0;
        ev_fmt_next   = '0;
        unique case (req_reg)
            REQ_LOOKUP: begin
                if (match_found_reg) begin
                    hit_next     = 1'b1;
                    hit_tag_next = match_ent_reg.tag;
                    sync_next    = (match_ent_reg.rev != rev_reg);
                end
            end
            REQ_INSERT: begin
                if (free_found_reg) begin
                    wr_en                     = cmd.commit;
                    valid_next[free_slot_reg] = 1'b1;
                    age_next                  = age_reg + AGE_W'(1);
                    count_next                = count_after;
                    if (({{LIMIT_W{1'b0}}, count_after} > limit) && old_found_reg) begin
                        valid_next[old_slot_reg] = 1'b0;
                        count_next               = count_reg;
                        ev_next                  = 1'b1;
                        ev_index_next            = old_ent_reg.index;
                        ev_tag_next              = old_ent_reg.tag;
                        ev_fmt_next              = old_ent_reg.fmt;
                    end
                end
            end
            REQ_CLOSE: begin
                if (match_found_reg) begin
                    hit_next                   = 1'b1;
                    hit_tag_next               = match_ent_reg.tag;
                    valid_next[match_slot_reg] = 1'b0;
                    count_next                 = count_reg - CW'(1);
                    ev_next                    = 1'b1;
                    ev_index_next              = match_ent_reg.index;
                    ev_tag_next                = match_ent_reg.tag;
                    ev_fmt_next                = match_ent_reg.fmt;
                end
            end
            REQ_NOP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            count_reg   <= '0;
            age_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                valid_reg   <= valid_next;
                count_reg   <= count_next;
                age_reg     <= age_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            hit_reg      <= hit_next;
            hit_tag_reg  <= hit_tag_next;
            sync_reg     <= sync_next;
            ev_reg       <= ev_next;
            ev_index_reg <= ev_index_next;
            ev_tag_reg   <= ev_tag_next;
            ev_fmt_reg   <= ev_fmt_next;
            open_reg     <= OPEN_W'(count_next);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_hit            = hit_reg;
    assign m_hit_tag        = hit_tag_reg;
    assign m_sync_needed    = sync_reg;
    assign m_evicted        = ev_reg;
    assign m_evicted_index  = ev_index_reg;
    assign m_evicted_tag    = ev_tag_reg;
    assign m_evicted_format = ev_fmt_reg;
    assign m_open_count     = open_reg;

endmodule

@@ hw/rtl/open_handle_cache_oldest_evict_unit.sv @@
// top level of the open handle cache with oldest-first eviction
// depends on ohc_pkg, ohc_ctrl and ohc_datapath
//
// Fully associative table of TABLE_DEPTH open file handles. A lookup beat
// returns hit, the stored handle and a sync flag (stored revision differs
// from the given one; the stored revision is not updated). An insert beat
// takes the lowest free slot, stamps it from a wrapping 32-bit age counter,
// and when the open count then exceeds the limit (max_open, 0 treated as 1,
// capped at TABLE_DEPTH-1) removes and reports the oldest other entry. A
// force close beat removes the newest entry with the given index. Duplicate
// inserts are kept; lookup and close pick the newest match. Every request
// beat gives exactly one result beat. Scan: the entry memory has a single
// registered read port and is scanned one slot per cycle; a drain state
// then compares the last slot read and a commit state writes the result
// register. A new request is taken only in the idle state, after the
// previous commit, which waits while a previous result is still not
// taken. A finished result sits in the output register while the next
// request is scanned. The config channel is ready whenever reset is not
// held; write max_open only while no request is in flight. No clearing pass
// is needed after reset: per-slot valid bits in flip-flops clear at once.
module open_handle_cache_oldest_evict_unit #(
    parameter int unsigned TABLE_DEPTH = ohc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ohc_pkg::LIMIT_W-1:0]   cfg_max_open,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ohc_pkg::REQ_W-1:0]     s_req_type,
    input  logic [ohc_pkg::INDEX_W-1:0]   s_file_index,
    input  logic [ohc_pkg::REV_W-1:0]     s_current_rev,
    input  logic [ohc_pkg::TAG_W-1:0]     s_new_tag,
    input  logic [ohc_pkg::FMT_W-1:0]     s_format_type,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic [ohc_pkg::TAG_W-1:0]     m_hit_tag,
    output logic                          m_sync_needed,
    output logic                          m_evicted,
    output logic [ohc_pkg::INDEX_W-1:0]   m_evicted_index,
    output logic [ohc_pkg::TAG_W-1:0]     m_evicted_tag,
    output logic [ohc_pkg::FMT_W-1:0]     m_evicted_format,
    output logic [ohc_pkg::OPEN_W-1:0]    m_open_count
);
    import ohc_pkg::*;

    ohc_cmd_t cmd;
    ohc_sts_t sts;

    // max_open writes are registered directly, never stalled outside reset
    assign cfg_ready = aresetn;

    // request sequencing: idle, scan, drain, commit
    ohc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // table storage, search and result register
    ohc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_valid        (cfg_valid),
        .cfg_max_open     (cfg_max_open),
        .s_req_type       (s_req_type),
        .s_file_index     (s_file_index),
        .s_current_rev    (s_current_rev),
        .s_new_tag        (s_new_tag),
        .s_format_type    (s_format_type),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hit            (m_hit),
        .m_hit_tag        (m_hit_tag),
        .m_sync_needed    (m_sync_needed),
        .m_evicted        (m_evicted),
        .m_evicted_index  (m_evicted_index),
        .m_evicted_tag    (m_evicted_tag),
        .m_evicted_format (m_evicted_format),
        .m_open_count     (m_open_count)
    );

endmodule
